[hdl/itrb_pkg.sv]
`default_nettype none

package itrb_pkg;

	// Default geometry
	localparam int DEPTH_DEF      = 16;
	localparam int INST_BYTES_DEF = 4;

	// Fixed field widths
	localparam int ADDR_W = 32;
	localparam int WORD_W = 32;

	// Operation codes
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic rec_en;     // write one entry at the write pointer
		logic dump_load;  // set up the read pointer and remaining count
		logic rd_step;    // read one entry and advance
		logic emit_empty; // send the empty-buffer result
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cnt_zero;   // buffer holds no entries
		logic rd_final;   // the current read is the last of the dump
	} dp_status_t;

endpackage

`default_nettype wire

[hdl/instruction_trace_ring_buffer.sv]
// Channel   Ports                                              Transaction
// command   start, busy, operation, instr_addr, instr_word,    start && !busy
//           fault_addr
// result    strobe, entry_addr, entry_word, is_fault,          strobe (one cycle)
//           is_empty, last
//
// A record does not raise busy, so records go in every cycle while no dump holds busy.
// A dump of N valid entries holds busy while it makes N reads, one memory read per cycle
// on the single read port; each read passes through the stage 1 and output registers.
// A dump of an empty buffer does not raise busy and gives one result.
// Reset clears the write pointer and entry count; storage is not cleared.
// Results cannot be stalled; each strobe lasts one cycle.
`default_nettype none

module instruction_trace_ring_buffer
	import itrb_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int INST_BYTES = INST_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              operation,
	input  wire logic [ADDR_W-1:0] instr_addr,
	input  wire logic [WORD_W-1:0] instr_word,
	input  wire logic [ADDR_W-1:0] fault_addr,
	output logic                   strobe,
	output logic [ADDR_W-1:0]      entry_addr,
	output logic [WORD_W-1:0]      entry_word,
	output logic                   is_fault,
	output logic                   is_empty,
	output logic                   last
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	itrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	itrb_dp #(
		.DEPTH      (DEPTH),
		.INST_BYTES (INST_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.instr_addr (instr_addr),
		.instr_word (instr_word),
		.fault_addr (fault_addr),
		.status     (status),
		.strobe     (strobe),
		.entry_addr (entry_addr),
		.entry_word (entry_word),
		.is_fault   (is_fault),
		.is_empty   (is_empty),
		.last       (last)
	);

endmodule

`default_nettype wire

[hdl/itrb_ctrl.sv]
`default_nettype none

module itrb_ctrl
	import itrb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       operation,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q == ST_DUMP);

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.rec_en     = accept && (operation == OP_RECORD);
		cmd.dump_load  = accept && (operation == OP_DUMP) && !status.cnt_zero;
		cmd.emit_empty = accept && (operation == OP_DUMP) && status.cnt_zero;
		cmd.rd_step    = (state_q == ST_DUMP);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.dump_load) begin
						state_q <= ST_DUMP;
					end
				end
				ST_DUMP: begin
					if (status.rd_final) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/itrb_dp.sv]
`default_nettype none

module itrb_dp
	import itrb_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int INST_BYTES = INST_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	input  wire logic [ADDR_W-1:0] instr_addr,
	input  wire logic [WORD_W-1:0] instr_word,
	input  wire logic [ADDR_W-1:0] fault_addr,
	output dp_status_t             status,
	output logic                   strobe,
	output logic [ADDR_W-1:0]      entry_addr,
	output logic [WORD_W-1:0]      entry_word,
	output logic                   is_fault,
	output logic                   is_empty,
	output logic                   last
);

	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int KEEP_BYTES = (INST_BYTES >= 4) ? 4 : INST_BYTES;
	localparam logic [WORD_W-1:0] WORD_MASK = (KEEP_BYTES == 4) ? {WORD_W{1'b1}} :
		WORD_W'((64'd1 << (8 * KEEP_BYTES)) - 64'd1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

	// Trace storage
	logic [ADDR_W-1:0] addr_mem [DEPTH];
	logic [WORD_W-1:0] word_mem [DEPTH];

	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  rd_left_q;
	logic [ADDR_W-1:0] fault_q;

	logic [ADDR_W-1:0] rd_addr_s1;
	logic [WORD_W-1:0] rd_word_s1;
	logic              vld_s1;
	logic              empty_s1;
	logic              last_s1;

	logic              full;

	assign full            = (count_q == CNT_MAX);
	assign status.cnt_zero = (count_q == '0);
	assign status.rd_final = (rd_left_q == CNT_W'(1));

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.rec_en) begin
			addr_mem[wr_ptr_q] <= instr_addr;
			word_mem[wr_ptr_q] <= instr_word & WORD_MASK;
		end
		if (cmd.rd_step) begin
			rd_addr_s1 <= addr_mem[rd_ptr_q];
			rd_word_s1 <= word_mem[rd_ptr_q];
		end
	end

	// Fault address held for the length of a dump
	always_ff @(posedge clk) begin
		if (cmd.dump_load || cmd.emit_empty) begin
			fault_q <= fault_addr;
		end
	end

	// Pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			rd_left_q <= '0;
		end else begin
			if (cmd.rec_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.dump_load) begin
				// oldest entry: slot 0 until the buffer wraps, then the write pointer
				rd_ptr_q  <= full ? wr_ptr_q : '0;
				rd_left_q <= count_q;
			end else if (cmd.rd_step) begin
				rd_ptr_q  <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
				rd_left_q <= rd_left_q - CNT_W'(1);
			end
		end
	end

	// Stage 1 control, alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			empty_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_step || cmd.emit_empty;
			empty_s1 <= cmd.emit_empty;
			last_s1  <= cmd.emit_empty || (cmd.rd_step && status.rd_final);
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe   <= 1'b0;
			is_empty <= 1'b0;
			last     <= 1'b0;
		end else begin
			strobe   <= vld_s1;
			is_empty <= empty_s1;
			last     <= last_s1;
		end
	end

	// Output payload with fault compare
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			entry_addr <= empty_s1 ? '0 : rd_addr_s1;
			entry_word <= empty_s1 ? '0 : rd_word_s1;
			is_fault   <= !empty_s1 && (rd_addr_s1 == fault_q);
		end
	end

endmodule

`default_nettype wire
